@@ sv/arp_cache_insert_lookup_top_defines.svh @@
// Assertion macros for the file that carries concurrent checks.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ARP_CACHE_INSERT_LOOKUP_TOP_DEFINES_SVH
`define ARP_CACHE_INSERT_LOOKUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arp cache check failed");

// The consequent must hold in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arp cache check failed");

`endif

@@ sv/arpc_pkg.sv @@
package arpc_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ST_W  = 2;

    // Result status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // Request modes.
    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_LOOKUP = 1'b1
    } t_mode;

    // Outcome of comparing the request key against one stored entry.
    typedef struct packed {
        logic ip_eq;
        logic pair_eq;
    } t_match;

endpackage

@@ sv/arpc_if.sv @@
interface arpc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [arpc_pkg::IP_W-1:0]     ip_addr;
    logic [arpc_pkg::MAC_W-1:0]    mac_addr;

    modport source (output valid, mode, ip_addr, mac_addr, input ready);
    modport sink   (input valid, mode, ip_addr, mac_addr, output ready);
endinterface

interface arpc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [arpc_pkg::ST_W-1:0]     status;
    logic [arpc_pkg::MAC_W-1:0]    found_mac;

    modport source (output valid, status, found_mac, input ready);
    modport sink   (input valid, status, found_mac, output ready);
endinterface

@@ sv/arpc_ram.sv @@
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/arpc_match.sv @@
module arpc_match (
    input  logic [arpc_pkg::IP_W-1:0]  i_key_ip,
    input  logic [arpc_pkg::MAC_W-1:0] i_key_mac,
    input  logic [arpc_pkg::IP_W-1:0]  i_entry_ip,
    input  logic [arpc_pkg::MAC_W-1:0] i_entry_mac,
    output arpc_pkg::t_match           o_match
);

    logic ip_eq;
    logic mac_eq;

    assign ip_eq   = (i_key_ip == i_entry_ip);
    assign mac_eq  = (i_key_mac == i_entry_mac);

    assign o_match.ip_eq   = ip_eq;
    assign o_match.pair_eq = ip_eq && mac_eq;

endmodule

@@ sv/arp_cache_insert_lookup_top.sv @@
// Append-only ARP cache of IPv4-to-MAC pairs. Each request is an insert or a lookup
// and yields exactly one response. The entries sit in one synchronous RAM of
// TABLE_DEPTH words (IP and MAC side by side) and a request scans them oldest first,
// one read issued per cycle with each compare in the cycle after its read. A request
// is accepted in the idle state, then scans (ending early on a hit, and at once when
// the table is empty), then moves its answer into the output register. The RAM read
// port and the single-entry comparator pace the scan. An insert on a full table skips
// the scan. The output register lets a new request enter while the previous response
// still waits to be taken. There is no clearing pass after reset: only the first
// count entries are ever read.
`include "arp_cache_insert_lookup_top_defines.svh"

module arp_cache_insert_lookup_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arpc_req_if.sink    i_req,
    arpc_rsp_if.source  o_rsp
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = arpc_pkg::IP_W + arpc_pkg::MAC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state                      r_state,      n_state;
    logic                        r_mode,       n_mode;
    logic [arpc_pkg::IP_W-1:0]   r_ip,         n_ip;
    logic [arpc_pkg::MAC_W-1:0]  r_mac,        n_mac;
    logic [CW-1:0]               r_count,      n_count;
    logic [CW-1:0]               r_rd_idx,     n_rd_idx;
    logic                        r_cmp_valid,  n_cmp_valid;
    logic [CW-1:0]               r_cmp_idx,    n_cmp_idx;
    arpc_pkg::t_status           r_p_status,   n_p_status;
    logic [arpc_pkg::MAC_W-1:0]  r_p_mac,      n_p_mac;
    logic                        r_out_valid,  n_out_valid;
    arpc_pkg::t_status           r_out_status, n_out_status;
    logic [arpc_pkg::MAC_W-1:0]  r_out_mac,    n_out_mac;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic [EW-1:0]               ram_wdata;
    logic [IW-1:0]               ram_raddr;
    logic [EW-1:0]               ram_rdata;
    logic [arpc_pkg::IP_W-1:0]   entry_ip;
    logic [arpc_pkg::MAC_W-1:0]  entry_mac;
    arpc_pkg::t_match            match;

    logic                        table_full;
    logic                        hit;
    logic                        last_cmp;
    logic                        issue;

    // Entry storage: IP in the upper bits, MAC in the lower bits.
    arpc_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign entry_ip  = ram_rdata[EW-1 -: arpc_pkg::IP_W];
    assign entry_mac = ram_rdata[arpc_pkg::MAC_W-1:0];

    arpc_match u_match (
        .i_key_ip    (r_ip),
        .i_key_mac   (r_mac),
        .i_entry_ip  (entry_ip),
        .i_entry_mac (entry_mac),
        .o_match     (match)
    );

    // A lookup matches on the IP alone, an insert looks for the exact pair.
    assign hit        = (r_mode == arpc_pkg::MODE_LOOKUP) ? match.ip_eq : match.pair_eq;
    assign table_full = (r_count == CW'(TABLE_DEPTH));
    assign last_cmp   = ((r_cmp_idx + CW'(1)) == r_count);
    assign issue      = (r_rd_idx < r_count);

    // The RAM write happens in the cycle that ends a scan, and the next scan issues
    // its first read only after the response and idle states, so a read never meets a
    // write to the same entry and no forwarding is needed.
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_ip         = r_ip;
        n_mac        = r_mac;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_cmp_valid  = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_p_status   = r_p_status;
        n_p_mac      = r_p_mac;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_mac    = r_out_mac;

        ram_we    = 1'b0;
        ram_waddr = r_count[IW-1:0];
        ram_wdata = {r_ip, r_mac};
        ram_raddr = r_rd_idx[IW-1:0];

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode   = i_req.mode;
                    n_ip     = i_req.ip_addr;
                    n_mac    = i_req.mac_addr;
                    n_rd_idx = '0;
                    // A full table rejects an insert before any duplicate check.
                    if (i_req.mode == arpc_pkg::MODE_INSERT && table_full) begin
                        n_p_status = arpc_pkg::ST_FULL;
                        n_p_mac    = '0;
                        n_state    = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                n_cmp_valid = issue;
                n_cmp_idx   = r_rd_idx;
                if (r_cmp_valid && hit) begin
                    // Oldest match wins; a duplicate insert changes nothing.
                    n_p_status  = arpc_pkg::ST_OK;
                    n_p_mac     = (r_mode == arpc_pkg::MODE_LOOKUP) ? entry_mac : '0;
                    n_cmp_valid = 1'b0;
                    n_state     = S_RESP;
                end else if ((r_count == '0) || (r_cmp_valid && last_cmp)) begin
                    n_p_mac     = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = S_RESP;
                    if (r_mode == arpc_pkg::MODE_LOOKUP) begin
                        n_p_status = arpc_pkg::ST_MISS;
                    end else begin
                        ram_we     = 1'b1;
                        n_count    = r_count + CW'(1);
                        n_p_status = arpc_pkg::ST_OK;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_p_status;
                    n_out_mac    = r_p_mac;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_ip         <= n_ip;
        r_mac        <= n_mac;
        r_cmp_idx    <= n_cmp_idx;
        r_p_status   <= n_p_status;
        r_p_mac      <= n_p_mac;
        r_out_status <= n_out_status;
        r_out_mac    <= n_out_mac;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.found_mac = r_out_mac;

    // The entry count never passes the table size.
    `ARPC_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(TABLE_DEPTH))

    // An insert that meets a full table leaves the count alone.
    `ARPC_ASSERT_NEXT(a_full_no_grow,
        i_req.valid && i_req.ready && (i_req.mode == arpc_pkg::MODE_INSERT) && table_full,
        r_count == $past(r_count))

    // Every RAM write appends exactly one entry.
    `ARPC_ASSERT_NEXT(a_write_grows, ram_we, r_count == $past(r_count) + CW'(1))

    // Read data is compared only while a scan is running.
    `ARPC_ASSERT_IMP(a_cmp_in_scan, r_cmp_valid, r_state == S_SCAN)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import arpc_pkg::*;

    localparam int DEPTH          = 16;
    localparam int PROBES         = 20;
    localparam int RANDOM_ITEMS   = 1780;
    localparam int QUIET_TAIL     = 200;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    // One response as the block should report it.
    typedef struct packed {
        t_status            status;
        logic [MAC_W-1:0]   mac;
    } t_answer;

    // One row of the directed table. When typed is set, want is the response
    // read straight off the behavior; otherwise the shadow table decides.
    typedef struct packed {
        t_mode              mode;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        bit                 typed;
        t_answer            want;
    } t_probe;

    logic i_clk;
    logic i_rst_n;

    arpc_req_if req_bus ();
    arpc_rsp_if rsp_bus ();

    arp_cache_insert_lookup_top #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    // Shadow copy of the cache: pairs in arrival order and the fill level.
    logic [IP_W-1:0]  cache_ip  [DEPTH];
    logic [MAC_W-1:0] cache_mac [DEPTH];
    int               cache_used;

    t_answer answers_due[$];
    int      fault_count;
    bit      gaps_on;

    // Edge cases first: empty-table misses, all-zero and all-one keys, a
    // repeated pair, the same IP with MACs that differ only in the lowest or
    // highest byte, and MACs with a zero byte ahead of the differing byte, so
    // a compare that stops at a zero byte would be caught.
    t_probe probe_table [PROBES] = '{
        '{MODE_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_MISS, 48'h0}},
        '{MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, '{ST_MISS, 48'h0}},
        '{MODE_INSERT, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1,
          '{ST_OK, 48'hFFFF_FFFF_FFFF}},
        '{MODE_INSERT, 32'h0000_0000, 48'h0000_0000_0000, 1'b1, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h0000_0000, 48'h0000_0000_0001, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h0000_0000, 48'h8000_0000_0000, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h0000_0000, 48'h1234_5678_9ABC, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h0A00_0001, 48'h00AA_BBCC_DD00, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h0A00_0001, 48'h00AA_BBCC_DD01, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h0A00_0001, 48'h00AA_BBCC_DD00, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h0A00_0001, 48'h0000_0000_0000, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h0A00_0002, 48'h0000_0000_0000, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'h8000_0000, 48'h7FFF_FFFF_FFFF, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_LOOKUP, 32'h8000_0000, 48'h0000_0000_0000, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, '{ST_OK, 48'h0}},
        '{MODE_INSERT, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFE, 1'b0, '{ST_OK, 48'h0}}
    };

    // Applies one accepted request to the shadow cache and returns the
    // response it must produce.
    function automatic t_answer resolve_request(t_mode mode, logic [IP_W-1:0] ip,
                                                logic [MAC_W-1:0] mac);
        t_answer ans;
        bit      seen;
        ans.status = ST_OK;
        ans.mac    = '0;
        seen       = 1'b0;
        if (mode == MODE_INSERT) begin
            // A full table refuses the insert before any duplicate search.
            if (cache_used >= DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                for (int k = 0; k < cache_used; k++) begin
                    if (cache_ip[k] == ip && cache_mac[k] == mac) seen = 1'b1;
                end
                if (!seen) begin
                    cache_ip[cache_used]  = ip;
                    cache_mac[cache_used] = mac;
                    cache_used++;
                end
            end
        end else begin
            // The oldest entry with a matching IP wins.
            ans.status = ST_MISS;
            for (int k = 0; k < cache_used && !seen; k++) begin
                if (cache_ip[k] == ip) begin
                    seen       = 1'b1;
                    ans.status = ST_OK;
                    ans.mac    = cache_mac[k];
                end
            end
        end
        return ans;
    endfunction

    // Drives one request from the falling edge and holds it until accepted.
    task automatic issue_request(t_mode mode, logic [IP_W-1:0] ip,
                                 logic [MAC_W-1:0] mac, bit typed, t_answer typed_ans);
        t_answer ans;
        @(negedge i_clk);
        req_bus.valid    = 1'b1;
        req_bus.mode     = mode;
        req_bus.ip_addr  = ip;
        req_bus.mac_addr = mac;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        ans = resolve_request(mode, ip, mac);
        if (typed) ans = typed_ans;
        answers_due.push_back(ans);
    endtask

    task automatic pause_sender(int cycles);
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Holds off new requests until every outstanding response is back.
    task automatic drain_responses();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    // Random requests lean on what is stored: before the table fills, most
    // inserts repeat a stored pair so the fill is slow and duplicates are
    // frequent; new pairs often reuse a stored IP with a fresh MAC. Once full,
    // inserts mix stored pairs and fresh ones. Lookups mostly hit.
    task automatic draft_random_request(output t_mode mode, output logic [IP_W-1:0] ip,
                                        output logic [MAC_W-1:0] mac);
        int          slot;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        mac  = wide[MAC_W-1:0];
        ip   = $urandom;
        mode = t_mode'($urandom_range(0, 1));
        slot = (cache_used != 0) ? $urandom_range(0, cache_used - 1) : 0;
        if (cache_used != 0) begin
            if (mode == MODE_INSERT) begin
                if (cache_used < DEPTH) begin
                    if ($urandom_range(0, 15) != 0) begin
                        ip  = cache_ip[slot];
                        mac = cache_mac[slot];
                    end else if ($urandom_range(0, 1) == 1) begin
                        ip = cache_ip[slot];
                    end
                end else begin
                    case ($urandom_range(0, 2))
                        0: begin
                            ip  = cache_ip[slot];
                            mac = cache_mac[slot];
                        end
                        1: ip = cache_ip[slot];
                        default: ;
                    endcase
                end
            end else if ($urandom_range(0, 4) < 3) begin
                ip = cache_ip[slot];
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Response side: ready drops in random bursts while gaps are enabled.
    initial begin
        int hold_left;
        hold_left     = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                rsp_bus.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_bus.ready = 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0) hold_left = $urandom_range(1, 19);
            end
        end
    end

    // Every response taken is compared with the oldest one still owed.
    always @(posedge i_clk) begin : check_responses
        t_answer want;
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
                if (fault_count < 10)
                    $display("%0t: response with none pending: status %0d mac %h",
                             $realtime, rsp_bus.status, rsp_bus.found_mac);
                fault_count++;
            end else begin
                want = answers_due.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.found_mac !== want.mac) begin
                    if (fault_count < 10)
                        $display("%0t: expected status %0d mac %h, got status %0d mac %h",
                                 $realtime, want.status, want.mac,
                                 rsp_bus.status, rsp_bus.found_mac);
                    fault_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves for too long.
    initial begin
        int stuck;
        stuck = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
                stuck = 0;
            else
                stuck++;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_mode            mode;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        fault_count      = 0;
        cache_used       = 0;
        gaps_on          = 1'b1;
        req_bus.valid    = 1'b0;
        req_bus.mode     = MODE_INSERT;
        req_bus.ip_addr  = '0;
        req_bus.mac_addr = '0;
        i_rst_n          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < PROBES; n++) begin
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 19));
            issue_request(probe_table[n].mode, probe_table[n].ip, probe_table[n].mac,
                          probe_table[n].typed, probe_table[n].want);
        end
        drain_responses();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Alternate stretches with and without gaps; none at the tail.
            gaps_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 80) % 4 != 3);
            if (n == RANDOM_ITEMS / 2) drain_responses();
            if (gaps_on && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 19));
            draft_random_request(mode, ip, mac);
            issue_request(mode, ip, mac, 1'b0, '0);
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && answers_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
